// ===== rtl/chisq_pkg.sv =====
package chisq_pkg;

  // Fixed field widths.
  localparam int IN_W      = 16;
  localparam int STAT_W    = 44;
  localparam int FRAC_W    = 16;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

  localparam logic [STAT_W-1:0] STAT_MAX = {STAT_W{1'b1}};

  // Products formed by the shared serial multiplier for one term.
  typedef enum logic [2:0] {
    OP_OBS  = 3'd0,
    OP_MARG = 3'd1,
    OP_DEV  = 3'd2,
    OP_NR   = 3'd3,
    OP_DEN  = 3'd4
  } mul_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    loading;
    logic    mem_read;
    logic    mul_load;
    logic    mul_store;
    mul_op_t mul_sel;
    logic    div_load;
    logic    acc;
    logic    emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic load_last;
    logic empty;
    logic mul_done;
    logic div_done;
    logic last_term;
    logic out_free;
  } status_t;

  // A size of zero counts as one, and a size above the maximum saturates.
  function automatic logic [CFG_W-1:0] clamp_size(logic [CFG_W-1:0] v, int max);
    if (v == '0) return CFG_W'(1);
    if (int'(v) > max) return CFG_W'(max);
    return v;
  endfunction

endpackage

// ===== rtl/chisq_ctrl.sv =====
module chisq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  chisq_pkg::status_t st,
  output chisq_pkg::cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_LOAD    = 8'b0000_0001,
    S_READ    = 8'b0000_0010,
    S_MUL_LD  = 8'b0000_0100,
    S_MUL_RUN = 8'b0000_1000,
    S_DIV_LD  = 8'b0001_0000,
    S_DIV_RUN = 8'b0010_0000,
    S_ACC     = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  state_t             state_r, state_nxt;
  chisq_pkg::mul_op_t op_r, op_nxt;

  // State and product selection registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      op_r    <= chisq_pkg::OP_OBS;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  // Sequencing: load, then per term read, five products, divide, accumulate; then emit.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cmd           = '0;
    cmd.mul_sel   = op_r;
    case (state_r)
      S_LOAD: begin
        cmd.loading = 1'b1;
        if (st.load_last) state_nxt = S_READ;
      end
      S_READ: begin
        cmd.mem_read = 1'b1;
        if (st.empty) begin
          state_nxt = S_DONE;
        end else begin
          op_nxt    = chisq_pkg::OP_OBS;
          state_nxt = S_MUL_LD;
        end
      end
      S_MUL_LD: begin
        cmd.mul_load = 1'b1;
        state_nxt    = S_MUL_RUN;
      end
      S_MUL_RUN: begin
        if (st.mul_done) begin
          cmd.mul_store = 1'b1;
          state_nxt     = S_MUL_LD;
          case (op_r)
            chisq_pkg::OP_OBS:  op_nxt = chisq_pkg::OP_MARG;
            chisq_pkg::OP_MARG: op_nxt = chisq_pkg::OP_DEV;
            chisq_pkg::OP_DEV:  op_nxt = chisq_pkg::OP_NR;
            chisq_pkg::OP_NR:   op_nxt = chisq_pkg::OP_DEN;
            default:            state_nxt = S_DIV_LD;
          endcase
        end
      end
      S_DIV_LD: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        if (st.div_done) state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = st.last_term ? S_DONE : S_READ;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

endmodule

// ===== rtl/chisq_dpath.sv =====
module chisq_dpath #(
  parameter int MAX_ROWS   = 16,
  parameter int MAX_COLS   = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  chisq_pkg::cmd_t                     cmd,
  output chisq_pkg::status_t                  st,
  input  logic                                in_valid,
  input  logic [chisq_pkg::IN_W-1:0]          in_cell_count,
  input  logic                                cfg_we,
  input  logic [chisq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [chisq_pkg::CFG_W-1:0]         cfg_data,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [chisq_pkg::STAT_W-1:0]        out_statistic,
  output logic                                out_status
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int IDXW  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int NW    = COUNT_BITS + $clog2(CELLS + 1);
  localparam int OBSW  = COUNT_BITS + NW;
  localparam int DEVW  = 2 * NW;
  localparam int PW    = 2 * DEVW;
  localparam int DENW  = 3 * NW;
  localparam int NUMW  = PW + chisq_pkg::FRAC_W;
  localparam int DCW   = $clog2(NUMW + 1);
  localparam int SW    = chisq_pkg::STAT_W;

  // Configuration and load position.
  logic [chisq_pkg::CFG_W-1:0] rcount_r, ccount_r;
  logic [RW-1:0]               row_r, i_r;
  logic [CW-1:0]               col_r, j_r;
  logic [IDXW-1:0]             idx_r, rd_r;

  // Table storage.
  logic [COUNT_BITS-1:0] cell_store_r [CELLS];
  logic [NW-1:0]         row_tot_r [MAX_ROWS];
  logic [NW-1:0]         col_tot_r [MAX_COLS];
  logic [NW-1:0]         n_r;
  logic                  empty_r;

  // Term operands and products.
  logic [COUNT_BITS-1:0] cell_q_r;
  logic [NW-1:0]         r_val_r, c_val_r;
  logic [OBSW-1:0]       obs_r;
  logic [DEVW-1:0]       marg_r;
  logic [PW-1:0]         num_r;
  logic [DEVW-1:0]       nr_r;
  logic [DENW-1:0]       den_r;

  // Serial multiplier.
  logic [PW-1:0]   mul_a_r, mul_acc_r, mul_a_nxt;
  logic [DEVW-1:0] mul_b_r, mul_b_nxt;

  // Serial divider.
  logic [NUMW-1:0] dn_r;
  logic [DENW-1:0] rem_r;
  logic [SW-1:0]   q_r;
  logic            over_r;
  logic [DCW-1:0]  cnt_r;

  logic [SW-1:0] sum_r;
  logic          out_valid_r;
  logic [SW-1:0] out_stat_r;
  logic          out_status_r;

  logic                  accept, first, last_col, last_row, i_last, j_last;
  logic [COUNT_BITS-1:0] x;
  logic [RW-1:0]         row_addr;
  logic [CW-1:0]         col_addr;
  logic [NW-1:0]         row_rd, col_rd, row_new, col_new, n_new;
  logic                  empty_nxt;
  logic [DEVW-1:0]       obs_x, dev;
  logic [DENW:0]         rem_sh, den_x;
  logic                  q_bit;
  logic [SW-1:0]         q_fin, sum_nxt;
  logic [SW:0]           sum_wide;

  // Load-side arithmetic: running totals and empty detection.
  assign accept   = in_valid & cmd.loading;
  assign x        = COUNT_BITS'(in_cell_count);
  assign first    = (row_r == '0) && (col_r == '0);
  assign last_col = col_r == CW'(ccount_r - 1'b1);
  assign last_row = row_r == RW'(rcount_r - 1'b1);
  assign row_addr = cmd.loading ? row_r : i_r;
  assign col_addr = cmd.loading ? col_r : j_r;
  assign row_rd   = row_tot_r[row_addr];
  assign col_rd   = col_tot_r[col_addr];
  assign row_new  = ((col_r == '0) ? NW'(0) : row_rd) + NW'(x);
  assign col_new  = ((row_r == '0) ? NW'(0) : col_rd) + NW'(x);
  assign n_new    = (first ? NW'(0) : n_r) + NW'(x);
  assign empty_nxt = (first ? 1'b0 : empty_r) | (last_col && row_new == '0) |
                     (last_row && col_new == '0);

  assign i_last = i_r == RW'(rcount_r - 1'b1);
  assign j_last = j_r == CW'(ccount_r - 1'b1);

  // Cell memory: one write port for loading, one registered read port.
  always_ff @(posedge clk) begin
    if (accept) cell_store_r[idx_r] <= x;
    if (cmd.mem_read) cell_q_r <= cell_store_r[rd_r];
  end

  // Row and column totals; the first cell of each overwrites the old sum.
  always_ff @(posedge clk) begin
    if (accept) begin
      row_tot_r[row_r] <= row_new;
      col_tot_r[col_r] <= col_new;
      n_r              <= n_new;
    end
    if (cmd.mem_read) begin
      r_val_r <= row_rd;
      c_val_r <= col_rd;
    end
  end

  // Control counters, configuration and accumulation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcount_r    <= chisq_pkg::CFG_W'(2);
      ccount_r    <= chisq_pkg::CFG_W'(2);
      row_r       <= '0;
      col_r       <= '0;
      idx_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      rd_r        <= '0;
      empty_r     <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == chisq_pkg::REG_ROWS)
          rcount_r <= chisq_pkg::clamp_size(cfg_data, MAX_ROWS);
        if (cfg_index == chisq_pkg::REG_COLS)
          ccount_r <= chisq_pkg::clamp_size(cfg_data, MAX_COLS);
        row_r <= '0;
        col_r <= '0;
        idx_r <= '0;
      end else if (accept) begin
        empty_r <= empty_nxt;
        if (last_col && last_row) begin
          row_r <= '0;
          col_r <= '0;
          idx_r <= '0;
          i_r   <= '0;
          j_r   <= '0;
          rd_r  <= '0;
          sum_r <= '0;
        end else begin
          idx_r <= idx_r + 1'b1;
          if (last_col) begin
            col_r <= '0;
            row_r <= row_r + 1'b1;
          end else begin
            col_r <= col_r + 1'b1;
          end
        end
      end
      if (cmd.acc) begin
        sum_r <= sum_nxt;
        rd_r  <= rd_r + 1'b1;
        if (j_last) begin
          j_r <= '0;
          i_r <= i_r + 1'b1;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  // Absolute deviation between observed and marginal products.
  assign obs_x = DEVW'(obs_r);
  assign dev   = (obs_x > marg_r) ? obs_x - marg_r : marg_r - obs_x;

  // Operand selection for the serial multiplier.
  always_comb begin
    mul_a_nxt = '0;
    mul_b_nxt = '0;
    case (cmd.mul_sel)
      chisq_pkg::OP_OBS: begin
        mul_a_nxt = PW'(cell_q_r);
        mul_b_nxt = DEVW'(n_r);
      end
      chisq_pkg::OP_MARG: begin
        mul_a_nxt = PW'(r_val_r);
        mul_b_nxt = DEVW'(c_val_r);
      end
      chisq_pkg::OP_DEV: begin
        mul_a_nxt = PW'(dev);
        mul_b_nxt = dev;
      end
      chisq_pkg::OP_NR: begin
        mul_a_nxt = PW'(n_r);
        mul_b_nxt = DEVW'(r_val_r);
      end
      chisq_pkg::OP_DEN: begin
        mul_a_nxt = PW'(nr_r);
        mul_b_nxt = DEVW'(c_val_r);
      end
      default: begin
        mul_a_nxt = '0;
        mul_b_nxt = '0;
      end
    endcase
  end

  // Shift-add multiplier: one multiplier bit per cycle, done when it runs out.
  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      mul_a_r   <= mul_a_nxt;
      mul_b_r   <= mul_b_nxt;
      mul_acc_r <= '0;
    end else if (mul_b_r != '0) begin
      if (mul_b_r[0]) mul_acc_r <= mul_acc_r + mul_a_r;
      mul_a_r <= mul_a_r << 1;
      mul_b_r <= mul_b_r >> 1;
    end
  end

  // Product capture.
  always_ff @(posedge clk) begin
    if (cmd.mul_store) begin
      case (cmd.mul_sel)
        chisq_pkg::OP_OBS:  obs_r  <= OBSW'(mul_acc_r);
        chisq_pkg::OP_MARG: marg_r <= DEVW'(mul_acc_r);
        chisq_pkg::OP_DEV:  num_r  <= mul_acc_r;
        chisq_pkg::OP_NR:   nr_r   <= DEVW'(mul_acc_r);
        chisq_pkg::OP_DEN:  den_r  <= DENW'(mul_acc_r);
        default:            num_r  <= num_r;
      endcase
    end
  end

  // Restoring divider: one quotient bit per cycle, overflow above 44 bits.
  assign den_x  = {1'b0, den_r};
  assign rem_sh = {rem_r, dn_r[NUMW-1]};
  assign q_bit  = rem_sh >= den_x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.div_load) begin
      cnt_r <= DCW'(NUMW);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dn_r   <= {num_r, chisq_pkg::FRAC_W'(0)};
      rem_r  <= '0;
      q_r    <= '0;
      over_r <= 1'b0;
    end else if (cnt_r != '0) begin
      rem_r  <= q_bit ? DENW'(rem_sh - den_x) : DENW'(rem_sh);
      q_r    <= {q_r[SW-2:0], q_bit};
      over_r <= over_r | q_r[SW-1];
      dn_r   <= dn_r << 1;
    end
  end

  // Saturating accumulation of the terms.
  assign q_fin    = over_r ? chisq_pkg::STAT_MAX : q_r;
  assign sum_wide = {1'b0, sum_r} + {1'b0, q_fin};
  assign sum_nxt  = sum_wide[SW] ? chisq_pkg::STAT_MAX : sum_wide[SW-1:0];

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_stat_r   <= empty_r ? '0 : sum_r;
      out_status_r <= empty_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_statistic = out_stat_r;
  assign out_status    = out_status_r;

  // Status back to the controller.
  assign st.load_last = accept & last_col & last_row;
  assign st.empty     = empty_r;
  assign st.mul_done  = mul_b_r == '0;
  assign st.div_done  = cnt_r == '0;
  assign st.last_term = i_last & j_last;
  assign st.out_free  = !out_valid_r || !out_stall;

endmodule

// ===== rtl/contingency_chi_square_statistic.sv =====
// Pearson chi-square statistic (no continuity correction) of a row_count by
// column_count table. Cells are taken one per cycle in row-major order; the
// request that carries the last cell starts a compute pass during which
// in_stall is high. The pass handles one cell at a time through a single
// shift-add multiplier (five products per cell, stepping through the
// multiplier bits up to the highest set bit) and a restoring divider (one
// quotient bit per cycle over the 16-bit-shifted numerator). The result is
// unsigned with 16 fraction bits and saturates to all ones; out_status is 1
// and the statistic 0 when some row or column in use sums to zero. Writing
// row_count or column_count discards a partly loaded table; a size of zero
// is taken as one.
module contingency_chi_square_statistic #(
  parameter int MAX_ROWS   = 16,
  parameter int MAX_COLS   = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [chisq_pkg::IN_W-1:0]      in_cell_count,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [chisq_pkg::STAT_W-1:0]    out_statistic,
  output logic                            out_status,
  input  logic                            cfg_we,
  input  logic [chisq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [chisq_pkg::CFG_W-1:0]     cfg_data
);

  chisq_pkg::cmd_t    cmd;
  chisq_pkg::status_t st;

  // Cells are taken only while the controller is loading.
  assign in_stall = !cmd.loading;

  chisq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  chisq_dpath #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_valid      (in_valid),
    .in_cell_count (in_cell_count),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_statistic (out_statistic),
    .out_status    (out_status)
  );

endmodule
